>>> design/baurc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baurc_pkg: shared types and codes for the button auto-repeat counter
// Holds the state machine encodings, the press flag bundle, the settings
// bundle and the settings register indices.
// ----------------------------------------------------------------------------
package baurc_pkg;

  localparam int unsigned CountW  = 4;
  localparam int unsigned PeriodW = 4;
  localparam int unsigned HoldW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;

  // Settings register indices.
  localparam logic [CfgIdxW-1:0] CFG_SLOW_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FAST_PERIOD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_MAX   = 2'd3;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_BOTH = 2'd1,
    F_UP   = 2'd2,
    F_DOWN = 2'd3
  } front_mode_t;

  typedef enum logic [2:0] {
    M_IDLE       = 3'd0,
    M_CLEAR      = 3'd1,
    M_UP_SLOW    = 3'd2,
    M_DOWN_SLOW  = 3'd3,
    M_UP_FAST    = 3'd4,
    M_DOWN_FAST  = 3'd5,
    M_UP_FIRST   = 3'd6,
    M_DOWN_FIRST = 3'd7
  } main_mode_t;

  // Press flags from the front machine, both in the lowest bit.
  typedef struct packed {
    logic down;
    logic up;
    logic both;
  } press_t;

  typedef struct packed {
    logic [PeriodW-1:0] slow_period;
    logic [PeriodW-1:0] fast_period;
    logic [HoldW-1:0]   hold_ticks;
    logic [CountW-1:0]  count_max;
  } cfg_t;

endpackage
`default_nettype wire

>>> design/baurc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baurc_front: button front machine
// Turns the two button levels into up, down or both flags; a change from up
// or down to both is direct, any other change of pressed set passes via idle.
// ----------------------------------------------------------------------------
module baurc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            btn_up,
  input  wire logic            btn_down,
  output baurc_pkg::press_t    flags_next
);
  import baurc_pkg::*;

  front_mode_t front_mode;
  front_mode_t front_mode_next;
  press_t      press_flags;
  logic        both;

  assign both = btn_up && btn_down;

  always_comb begin
    front_mode_next = front_mode;
    flags_next      = press_flags;
    unique case (front_mode)
      F_IDLE: begin
        if (both) begin
          front_mode_next = F_BOTH;
          flags_next      = '{down: 1'b0, up: 1'b0, both: 1'b1};
        end else if (btn_up) begin
          front_mode_next = F_UP;
          flags_next      = '{down: 1'b0, up: 1'b1, both: 1'b0};
        end else if (btn_down) begin
          front_mode_next = F_DOWN;
          flags_next      = '{down: 1'b1, up: 1'b0, both: 1'b0};
        end
      end
      F_BOTH: begin
        if (both) begin
          flags_next = '{down: 1'b0, up: 1'b0, both: 1'b1};
        end else begin
          front_mode_next = F_IDLE;
          flags_next.both = 1'b0;
        end
      end
      F_UP: begin
        if (both) begin
          front_mode_next = F_BOTH;
          flags_next      = '{down: 1'b0, up: 1'b0, both: 1'b1};
        end else if (btn_up) begin
          flags_next = '{down: 1'b0, up: 1'b1, both: 1'b0};
        end else begin
          front_mode_next = F_IDLE;
          flags_next.up   = 1'b0;
        end
      end
      F_DOWN: begin
        if (both) begin
          front_mode_next = F_BOTH;
          flags_next      = '{down: 1'b0, up: 1'b0, both: 1'b1};
        end else if (btn_down) begin
          flags_next = '{down: 1'b1, up: 1'b0, both: 1'b0};
        end else begin
          front_mode_next = F_IDLE;
          flags_next.down = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_mode  <= F_IDLE;
      press_flags <= '0;
    end else if (en) begin
      front_mode  <= front_mode_next;
      press_flags <= flags_next;
    end
  end

  // At most one flag is ever raised.
  a_flags_onehot0: assert property (@(posedge clk) disable iff (rst)
    $onehot0(press_flags))
    else $error("press flags hold more than one flag");

  // The up flag is always set in the up state.
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    (front_mode == F_UP) |-> press_flags.up)
    else $error("up state without up flag");

  // Leaving the up state for anything but both passes through idle.
  a_via_idle: assert property (@(posedge clk) disable iff (rst)
    ($past(front_mode) == F_UP && front_mode != F_UP && front_mode != F_BOTH)
      |-> front_mode == F_IDLE)
    else $error("front machine skipped idle");

endmodule
`default_nettype wire

>>> design/baurc_main.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baurc_main: auto-repeat machine and saturating counter
// Acts on the press flags: first step, slow repeat, fast repeat after the
// hold threshold, clear on both buttons. Gives the count after the tick.
// ----------------------------------------------------------------------------
module baurc_main (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire baurc_pkg::press_t            flags,
  input  wire baurc_pkg::cfg_t              cfg,
  output logic [baurc_pkg::CountW-1:0]      count_next
);
  import baurc_pkg::*;

  main_mode_t          main_mode;
  main_mode_t          main_mode_next;
  main_mode_t          mode_mid;
  logic [CountW-1:0]   counter;
  logic [HoldW-1:0]    up_hold_ticks, up_hold_ticks_next;
  logic [HoldW-1:0]    down_hold_ticks, down_hold_ticks_next;
  logic [PeriodW-1:0]  up_slow_timer, up_slow_timer_next;
  logic [PeriodW-1:0]  down_slow_timer, down_slow_timer_next;
  logic [PeriodW-1:0]  up_fast_timer, up_fast_timer_next;
  logic [PeriodW-1:0]  down_fast_timer, down_fast_timer_next;
  logic                step_up;
  logic                step_down;

  always_comb begin
    mode_mid             = main_mode;
    up_hold_ticks_next   = up_hold_ticks;
    down_hold_ticks_next = down_hold_ticks;
    up_slow_timer_next   = up_slow_timer;
    down_slow_timer_next = down_slow_timer;
    up_fast_timer_next   = up_fast_timer;
    down_fast_timer_next = down_fast_timer;
    step_up              = 1'b0;
    step_down            = 1'b0;
    count_next           = counter;

    // Transition on the press flags.
    unique case (main_mode)
      M_IDLE: begin
        if (flags.both) begin
          mode_mid = M_CLEAR;
        end else if (flags.up) begin
          mode_mid           = M_UP_FIRST;
          up_hold_ticks_next = up_hold_ticks + 8'd1;
        end else if (flags.down) begin
          mode_mid             = M_DOWN_FIRST;
          down_hold_ticks_next = down_hold_ticks + 8'd1;
        end else begin
          up_hold_ticks_next   = '0;
          down_hold_ticks_next = '0;
          up_slow_timer_next   = '0;
          down_slow_timer_next = '0;
          up_fast_timer_next   = '0;
          down_fast_timer_next = '0;
        end
      end
      M_CLEAR: begin
        if (!flags.both) begin
          mode_mid             = M_IDLE;
          up_hold_ticks_next   = '0;
          down_hold_ticks_next = '0;
          up_slow_timer_next   = '0;
          down_slow_timer_next = '0;
          up_fast_timer_next   = '0;
          down_fast_timer_next = '0;
        end
      end
      M_UP_SLOW: begin
        if (flags.both) begin
          mode_mid = M_CLEAR;
        end else if (up_hold_ticks >= cfg.hold_ticks) begin
          mode_mid           = M_UP_FAST;
          up_hold_ticks_next = '0;
        end else if (flags.up) begin
          up_hold_ticks_next = up_hold_ticks + 8'd1;
        end else begin
          mode_mid             = M_IDLE;
          up_hold_ticks_next   = '0;
          down_hold_ticks_next = '0;
          up_slow_timer_next   = '0;
          down_slow_timer_next = '0;
          up_fast_timer_next   = '0;
          down_fast_timer_next = '0;
        end
      end
      M_DOWN_SLOW: begin
        if (flags.both) begin
          mode_mid = M_CLEAR;
        end else if (down_hold_ticks >= cfg.hold_ticks) begin
          mode_mid             = M_DOWN_FAST;
          down_hold_ticks_next = '0;
        end else if (flags.down) begin
          down_hold_ticks_next = down_hold_ticks + 8'd1;
        end else begin
          mode_mid             = M_IDLE;
          up_hold_ticks_next   = '0;
          down_hold_ticks_next = '0;
          up_slow_timer_next   = '0;
          down_slow_timer_next = '0;
          up_fast_timer_next   = '0;
          down_fast_timer_next = '0;
        end
      end
      M_UP_FAST, M_DOWN_FAST: begin
        if (flags.both) begin
          mode_mid = M_CLEAR;
        end else if ((main_mode == M_UP_FAST) ? !flags.up : !flags.down) begin
          mode_mid             = M_IDLE;
          up_hold_ticks_next   = '0;
          down_hold_ticks_next = '0;
          up_slow_timer_next   = '0;
          down_slow_timer_next = '0;
          up_fast_timer_next   = '0;
          down_fast_timer_next = '0;
        end
      end
      M_UP_FIRST:   mode_mid = M_UP_SLOW;
      M_DOWN_FIRST: mode_mid = M_DOWN_SLOW;
    endcase

    // Action in the state just entered; the first-step states fold into
    // the slow states within the same tick.
    main_mode_next = mode_mid;
    unique case (mode_mid)
      M_IDLE: begin
      end
      M_CLEAR: begin
      end
      M_UP_SLOW: begin
        up_slow_timer_next = up_slow_timer_next + 4'd1;
        if (up_slow_timer_next == cfg.slow_period) begin
          up_slow_timer_next = '0;
          step_up            = 1'b1;
        end
      end
      M_DOWN_SLOW: begin
        down_slow_timer_next = down_slow_timer_next + 4'd1;
        if (down_slow_timer_next == cfg.slow_period) begin
          down_slow_timer_next = '0;
          step_down            = 1'b1;
        end
      end
      M_UP_FAST: begin
        up_fast_timer_next = up_fast_timer_next + 4'd1;
        if (up_fast_timer_next == cfg.fast_period) begin
          up_fast_timer_next = '0;
          step_up            = 1'b1;
        end
      end
      M_DOWN_FAST: begin
        down_fast_timer_next = down_fast_timer_next + 4'd1;
        if (down_fast_timer_next == cfg.fast_period) begin
          down_fast_timer_next = '0;
          step_down            = 1'b1;
        end
      end
      M_UP_FIRST: begin
        step_up        = 1'b1;
        main_mode_next = M_UP_SLOW;
      end
      M_DOWN_FIRST: begin
        down_fast_timer_next = '0;
        step_down            = 1'b1;
        main_mode_next       = M_DOWN_SLOW;
      end
    endcase

    // Saturating count update.
    if (mode_mid == M_CLEAR) begin
      count_next = '0;
    end else if (step_up && (counter < cfg.count_max)) begin
      count_next = counter + 4'd1;
    end else if (step_down && (counter != '0)) begin
      count_next = counter - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_mode       <= M_IDLE;
      counter         <= '0;
      up_hold_ticks   <= '0;
      down_hold_ticks <= '0;
      up_slow_timer   <= '0;
      down_slow_timer <= '0;
      up_fast_timer   <= '0;
      down_fast_timer <= '0;
    end else if (en) begin
      main_mode       <= main_mode_next;
      counter         <= count_next;
      up_hold_ticks   <= up_hold_ticks_next;
      down_hold_ticks <= down_hold_ticks_next;
      up_slow_timer   <= up_slow_timer_next;
      down_slow_timer <= down_slow_timer_next;
      up_fast_timer   <= up_fast_timer_next;
      down_fast_timer <= down_fast_timer_next;
    end
  end

  // The first-step states are only passed through within a tick.
  a_no_first_state: assert property (@(posedge clk) disable iff (rst)
    main_mode != M_UP_FIRST && main_mode != M_DOWN_FIRST)
    else $error("first-step state was stored");

  // Holding both buttons keeps the count at zero.
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    main_mode == M_CLEAR |-> counter == '0)
    else $error("count not zero while clearing");

  // The count moves by at most one per tick, or is cleared.
  a_step_one: assert property (@(posedge clk) disable iff (rst)
    en |=> (counter == $past(counter) || counter == $past(counter) + 1 ||
            counter == $past(counter) - 1 || counter == '0))
    else $error("count jumped by more than one");

endmodule
`default_nettype wire

>>> design/button_auto_repeat_up_down_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_auto_repeat_up_down_counter: two-button up/down counter with repeat
// Each request is one timer tick with the up and down button levels; the
// block returns the count after that tick, saturating at 0 and count_max.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Payload (lowest bit first)        One per
//  s_axis     in         tdata: btn_up, btn_down, zeros    timer tick
//  m_axis     out        tdata: count_value[3:0], zeros    timer tick
//  cfg        in         cfg_index selects, cfg_data value register write
//
// A tick request is captured in an input register; when the result register
// is free, both state machines and the counter update in one pass and the
// count lands in it. One request is taken every cycle unless output stalls.
// The result register separates the sides: a new request is taken while a
// result still waits, and the block stalls only when both registers are full.
// Synchronous reset restores the default settings, idles both machines and
// clears the count and all timers. The user must write settings only while
// idle; the block itself does not enforce it.
module button_auto_repeat_up_down_counter (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,   // btn_up, btn_down
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // count_value
  input  wire logic                         cfg_we,
  input  wire logic [baurc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [baurc_pkg::CfgW-1:0]   cfg_data
);
  import baurc_pkg::*;

  cfg_t              cfg;
  logic              in_valid;
  logic              in_up;
  logic              in_down;
  logic              advance;
  logic              en;
  press_t            flags_next;
  logic [CountW-1:0] count_next;
  logic [CountW-1:0] out_count;

  // Settings registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slow_period <= 4'd10;
      cfg.fast_period <= 4'd4;
      cfg.hold_ticks  <= 8'd30;
      cfg.count_max   <= 4'd9;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOW_PERIOD: cfg.slow_period <= cfg_data[PeriodW-1:0];
        CFG_FAST_PERIOD: cfg.fast_period <= cfg_data[PeriodW-1:0];
        CFG_HOLD_TICKS:  cfg.hold_ticks  <= cfg_data[HoldW-1:0];
        CFG_COUNT_MAX:   cfg.count_max   <= cfg_data[CountW-1:0];
      endcase
    end
  end

  // The result register frees up when empty or being taken; the input
  // register moves on whenever the result register can take its tick.
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign en            = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_up   <= s_axis_tdata[0];
      in_down <= s_axis_tdata[1];
    end
  end

  baurc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .btn_up     (in_up),
    .btn_down   (in_down),
    .flags_next (flags_next)
  );

  baurc_main u_main (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .flags      (flags_next),
    .cfg        (cfg),
    .count_next (count_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_count <= count_next;
    end
  end

  assign m_axis_tdata = {{(8 - CountW){1'b0}}, out_count};

  // A result only appears for a tick that was waiting in the input register.
  a_out_from_in: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_valid))
    else $error("result appeared without a captured tick");

  // A held tick is never lost: while the input register is full and the
  // result is stalled, the tick stays put.
  a_hold_tick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("captured tick dropped while stalled");

  // The input register is always free when the result register is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("stalled with an empty result register");

endmodule
`default_nettype wire
